[rtl/edss_pkg.sv]
// Shared types and constants of the earliest-deadline slot scheduler.
// No dependencies; used by edss_cell, earliest_deadline_slot_scheduler and the testbench.

package edss_pkg;

  localparam int DL_W     = 10;
  localparam int ID_W     = 8;
  localparam int SLOT_W   = 11;
  localparam int STATUS_W = 3;
  localparam int APB_DW   = 32;
  localparam int APB_AW   = 3;

  localparam logic [SLOT_W-1:0] SLOT_COUNT_RST = 11'd1024;

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic REG_SLOT_COUNT = 1'b0;

  localparam logic [STATUS_W-1:0] ST_ADDED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EXPIRED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOGRANT = 3'd3;
  localparam logic [STATUS_W-1:0] ST_GRANTED = 3'd4;

  typedef struct packed {
    logic            cmd;
    logic [ID_W-1:0] job_id;
    logic [DL_W-1:0] deadline;
  } edss_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     granted_id;
    logic [SLOT_W-1:0]   slot;
  } edss_out_t;

  typedef struct packed {
    logic            valid;
    logic [DL_W-1:0] deadline;
    logic [ID_W-1:0] job_id;
  } edss_entry_t;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_POP    = 2'd2
  } edss_op_t;

  typedef struct packed {
    edss_op_t        op;
    logic [DL_W-1:0] deadline;
    logic [ID_W-1:0] job_id;
  } edss_ctrl_t;

endpackage

[rtl/earliest_deadline_slot_scheduler.sv]
// Earliest-deadline-first slot scheduler: top level with control, slot counter,
// configuration register and the chain of edss_cell. Depends on edss_pkg.
//
// Usage: the input channel (in_valid/in_stall/in_data) takes add and tick
// transactions; every one yields exactly one result transaction on the output
// channel (out_valid/out_stall/out_data). Pending jobs sit in a chain of
// MAX_JOBS cells kept sorted by deadline, then id; the head is the next grant.
// An add is resolved in its accept cycle and its result appears in the cycle
// after; back-to-back adds run at one per cycle while the output is not
// stalled. A tick enters the drop state, pops every expired job off the head
// of the chain, then, once the output register is free, grants the head or
// reports no grant and loads that result. Each job expires at most once, so
// the drop work stays bounded. Input is stalled while a tick is in work or
// while a result waits in the output register under out_stall; the result holds there.
// Reset empties the chain, sets the slot to zero and slot_count to 1024.
// The slot_count register sits at byte address 0 of the APB-style port.

module earliest_deadline_slot_scheduler #(
  parameter int MAX_JOBS  = 256,
  parameter int MAX_SLOTS = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  edss_pkg::edss_in_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output edss_pkg::edss_out_t             out_data,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [edss_pkg::APB_AW-1:0]     paddr,
  input  logic [edss_pkg::APB_DW-1:0]     pwdata,
  output logic [edss_pkg::APB_DW-1:0]     prdata,
  output logic                            pready
);
  import edss_pkg::*;

  localparam int SREG_W = $clog2(MAX_SLOTS + 1);
  localparam int CMP_W  = (SREG_W > SLOT_W) ? SREG_W : SLOT_W;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DROP = 2'b10
  } state_t;

  state_t            state_r, state_nxt;
  logic [SREG_W-1:0] slot_r, slot_nxt;
  logic [SLOT_W-1:0] slot_count_r;
  logic              out_valid_r;
  edss_out_t         out_data_r;

  edss_ctrl_t        ctrl;
  edss_entry_t       entries [MAX_JOBS];
  logic              gts     [MAX_JOBS];
  logic [MAX_JOBS-1:0] valid_vec;

  edss_out_t         res;
  logic              out_load;
  logic              out_free;
  logic              in_accept;
  logic              cfg_wr;
  logic [CMP_W-1:0]  slot_cmp;
  logic              head_expired;
  logic              can_grant;
  logic              add_expired;
  logic              full;

  // cell chain
  for (genvar i = 0; i < MAX_JOBS; i++) begin : g_cell
    edss_entry_t le, re;
    logic        lg;
    if (i == 0) begin : g_first
      assign le = '0;
      assign lg = 1'b0;
    end else begin : g_mid
      assign le = entries[i-1];
      assign lg = gts[i-1];
    end
    if (i == MAX_JOBS - 1) begin : g_last
      assign re = '0;
    end else begin : g_inner
      assign re = entries[i+1];
    end
    edss_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .left_entry  (le),
      .left_gt     (lg),
      .right_entry (re),
      .entry       (entries[i]),
      .gt          (gts[i])
    );
    assign valid_vec[i] = entries[i].valid;
  end

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE) || !out_free;
  assign in_accept = in_valid && !in_stall;

  assign slot_cmp     = CMP_W'(slot_r);
  assign head_expired = entries[0].valid && (CMP_W'(entries[0].deadline) < slot_cmp);
  assign add_expired  = CMP_W'(in_data.deadline) < slot_cmp;
  assign can_grant    = (slot_cmp < CMP_W'(slot_count_r)) && (slot_cmp < CMP_W'(MAX_SLOTS));
  assign full         = entries[MAX_JOBS-1].valid;

  always_comb begin
    state_nxt      = state_r;
    slot_nxt       = slot_r;
    ctrl.op        = OP_HOLD;
    ctrl.deadline  = in_data.deadline;
    ctrl.job_id    = in_data.job_id;
    out_load       = 1'b0;
    res.status     = ST_NOGRANT;
    res.granted_id = '0;
    res.slot       = SLOT_W'(slot_r);
    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          if (in_data.cmd == CMD_ADD) begin
            out_load = 1'b1;
            if (add_expired) begin
              res.status = ST_EXPIRED;
            end else if (full) begin
              res.status = ST_FULL;
            end else begin
              res.status = ST_ADDED;
              ctrl.op    = OP_INSERT;
            end
          end else begin
            state_nxt = S_DROP;
          end
        end
      end
      S_DROP: begin
        if (head_expired) begin
          ctrl.op = OP_POP;
        end else if (out_free) begin
          out_load = 1'b1;
          if (can_grant && entries[0].valid) begin
            ctrl.op        = OP_POP;
            res.status     = ST_GRANTED;
            res.granted_id = entries[0].job_id;
          end
          if (slot_cmp < CMP_W'(MAX_SLOTS)) begin
            slot_nxt = slot_r + SREG_W'(1);
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      slot_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      slot_r  <= slot_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // configuration
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_count_r <= SLOT_COUNT_RST;
    end else if (cfg_wr && (paddr[APB_AW-1:2] == REG_SLOT_COUNT)) begin
      slot_count_r <= pwdata[SLOT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[APB_AW-1:2] == REG_SLOT_COUNT) begin
      prdata = APB_DW'(slot_count_r);
    end
  end

  // checks
  a_chain_packed: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_vec & (valid_vec + MAX_JOBS'(1))) == '0)
    else $error("pending chain has a hole");

  a_chain_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    entries[1].valid |->
      ({entries[0].deadline, entries[0].job_id} <= {entries[1].deadline, entries[1].job_id}))
    else $error("pending chain head out of order");

  a_tick_enters_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_data.cmd == CMD_TICK) |=> (state_r == S_DROP))
    else $error("tick did not start drop phase");

  a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(slot_r) <= CMP_W'(MAX_SLOTS))
    else $error("slot counter past limit");

endmodule

[rtl/edss_cell.sv]
// One cell of the sorted job chain: holds one pending job and trades it with
// its neighbors on insert and pop. Depends on edss_pkg.

module edss_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  edss_pkg::edss_ctrl_t  ctrl,
  input  edss_pkg::edss_entry_t left_entry,
  input  logic                left_gt,
  input  edss_pkg::edss_entry_t right_entry,
  output edss_pkg::edss_entry_t entry,
  output logic                gt
);
  import edss_pkg::*;

  logic            valid_r, valid_nxt;
  logic [DL_W-1:0] deadline_r, deadline_nxt;
  logic [ID_W-1:0] job_id_r, job_id_nxt;

  assign entry = '{valid: valid_r, deadline: deadline_r, job_id: job_id_r};
  assign gt = !valid_r || ({deadline_r, job_id_r} > {ctrl.deadline, ctrl.job_id});

  always_comb begin
    valid_nxt    = valid_r;
    deadline_nxt = deadline_r;
    job_id_nxt   = job_id_r;
    case (ctrl.op)
      OP_INSERT: begin
        if (gt) begin
          if (left_gt) begin
            valid_nxt    = left_entry.valid;
            deadline_nxt = left_entry.deadline;
            job_id_nxt   = left_entry.job_id;
          end else begin
            valid_nxt    = 1'b1;
            deadline_nxt = ctrl.deadline;
            job_id_nxt   = ctrl.job_id;
          end
        end
      end
      OP_POP: begin
        valid_nxt    = right_entry.valid;
        deadline_nxt = right_entry.deadline;
        job_id_nxt   = right_entry.job_id;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    deadline_r <= deadline_nxt;
    job_id_r   <= job_id_nxt;
  end

endmodule

[sim/tb.sv]
// Testbench for earliest_deadline_slot_scheduler: random and directed add/tick
// transactions checked against an in-bench EDF predictor held in a small class.
// Depends on edss_pkg and the scheduler RTL.

module tb;
  import edss_pkg::*;

  localparam int JOBS     = 256;
  localparam int SLOTS    = 1024;
  localparam int HOLD     = 300;
  localparam int WATCHDOG = 3000;

  class edf_tracker;
    logic [SLOT_W-1:0] slot_limit;
    logic [DL_W-1:0]   dl_of[JOBS];
    logic [ID_W-1:0]   id_of[JOBS];
    bit                live[JOBS];
    int unsigned       now_slot;
    edss_out_t         due[$];
    int                faults;

    function new();
      slot_limit = SLOT_COUNT_RST;
      now_slot = 0;
      faults = 0;
      foreach (live[k]) live[k] = 1'b0;
    endfunction

    function void note_item(edss_in_t item);
      edss_out_t r;
      int free_k;
      int best;
      r.granted_id = '0;
      r.slot = now_slot[SLOT_W-1:0];
      if (item.cmd == CMD_ADD) begin
        free_k = -1;
        if (item.deadline < now_slot) begin
          r.status = ST_EXPIRED;
        end else begin
          for (int k = 0; k < JOBS; k++) begin
            if (!live[k]) begin
              free_k = k;
              break;
            end
          end
          if (free_k < 0) begin
            r.status = ST_FULL;
          end else begin
            live[free_k] = 1'b1;
            dl_of[free_k] = item.deadline;
            id_of[free_k] = item.job_id;
            r.status = ST_ADDED;
          end
        end
      end else begin
        for (int k = 0; k < JOBS; k++)
          if (live[k] && dl_of[k] < now_slot) live[k] = 1'b0;
        best = -1;
        if (now_slot < slot_limit && now_slot < SLOTS) begin
          for (int k = 0; k < JOBS; k++) begin
            if (live[k] && (best < 0 || dl_of[k] < dl_of[best] ||
                (dl_of[k] == dl_of[best] && id_of[k] < id_of[best])))
              best = k;
          end
        end
        if (best >= 0) begin
          live[best] = 1'b0;
          r.status = ST_GRANTED;
          r.granted_id = id_of[best];
        end else begin
          r.status = ST_NOGRANT;
        end
        if (now_slot < SLOTS) now_slot++;
      end
      due = {due, r};
    endfunction

    function void report(string what, int want, int got);
      if (faults < 10) $display("%s mismatch: expected %0d, got %0d", what, want, got);
      faults++;
    endfunction

    function void check_outcome(edss_out_t got);
      edss_out_t want;
      if (due.size() == 0) begin
        if (faults < 10)
          $display("unexpected result: status %0d id %0d slot %0d",
                   got.status, got.granted_id, got.slot);
        faults++;
        return;
      end
      want = due.pop_front();
      if (got.status !== want.status) report("status", want.status, got.status);
      if (got.granted_id !== want.granted_id)
        report("granted_id", want.granted_id, got.granted_id);
      if (got.slot !== want.slot) report("slot", want.slot, got.slot);
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  edss_in_t            in_data;
  logic                out_valid;
  logic                out_stall;
  edss_out_t           out_data;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  edf_tracker tracker;
  bit         hold_req;
  bit         hold_done;
  int         idle_cycles;

  earliest_deadline_slot_scheduler #(
    .MAX_JOBS(JOBS),
    .MAX_SLOTS(SLOTS)
  ) uut (.*);

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [DL_W-1:0] near_deadline(int offset);
    int d;
    d = int'(tracker.now_slot) + offset;
    if (d < 0) d = 0;
    if (d > 1023) d = 1023;
    return d[DL_W-1:0];
  endfunction

  task automatic send_item(edss_in_t item, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall !== 1'b0);
    tracker.note_item(item);
  endtask

  task automatic send_add(logic [ID_W-1:0] id, logic [DL_W-1:0] dl);
    edss_in_t item;
    item.cmd = CMD_ADD;
    item.job_id = id;
    item.deadline = dl;
    send_item(item, pick_gap());
  endtask

  task automatic send_tick();
    edss_in_t item;
    item.cmd = CMD_TICK;
    item.job_id = ID_W'($urandom_range(255));
    item.deadline = DL_W'($urandom_range(1023));
    send_item(item, pick_gap());
  endtask

  task automatic run_mix(int n, int tick_pct, int spread);
    edss_in_t item;
    int roll;
    for (int k = 0; k < n; k++) begin
      item.job_id = ID_W'($urandom_range(255));
      item.deadline = DL_W'($urandom_range(1023));
      if ($urandom_range(99) < tick_pct) begin
        item.cmd = CMD_TICK;
      end else begin
        item.cmd = CMD_ADD;
        roll = $urandom_range(99);
        if (roll < 85) item.deadline = near_deadline($urandom_range(0, spread));
        else if (roll < 93) item.deadline = near_deadline(-1);
      end
      send_item(item, (k < n / 5) ? 0 : pick_gap());
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_slot_count(logic [SLOT_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_SLOT_COUNT, 2'b00};
    pwdata <= APB_DW'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    tracker.slot_limit = value;
  endtask

  // receiver: random stall pattern, plus one long hold on request
  initial begin
    out_stall = 1'b0;
    forever begin
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        out_stall <= 1'b0;
        if ($urandom_range(9) == 0) repeat ($urandom_range(100, 200)) @(posedge clk);
        else repeat ($urandom_range(1, 40)) @(posedge clk);
        out_stall <= 1'b1;
        repeat (pick_gap() + 1) @(posedge clk);
      end
    end
  end

  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_stall === 1'b0) tracker.check_outcome(out_data);
      if ((in_valid === 1'b1 && in_stall === 1'b0) ||
          (out_valid === 1'b1 && out_stall === 1'b0))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG) begin
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    tracker = new();
    hold_req = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_add(8'h00, 10'd0);
    send_add(8'hFF, 10'h3FF);
    send_add(8'h55, 10'h2AA);
    send_add(8'hAA, 10'h155);
    send_add(8'h10, 10'd5);
    send_add(8'h10, 10'd5);
    send_add(8'h0F, 10'd5);
    send_tick();
    send_add(8'h01, 10'd0);
    send_tick();
    send_tick();
    send_tick();
    send_add(8'h20, 10'd4);
    send_add(8'h21, 10'd4);
    send_add(8'h22, 10'd4);
    send_tick();
    send_tick();
    send_add(8'h7F, 10'h200);
    send_tick();

    settle();
    write_slot_count(11'd0);
    run_mix(30, 50, 20);

    // load many jobs into the store and request the long hold of the result side
    settle();
    write_slot_count(11'd2047);
    hold_req = 1'b1;
    run_mix(280, 3, 400);
    run_mix(120, 70, 50);

    settle();
    write_slot_count(SLOT_W'(tracker.now_slot + $urandom_range(5, 60)));
    run_mix(200, 55, 40);

    settle();
    write_slot_count(11'd1);
    run_mix(20, 50, 20);

    settle();
    write_slot_count(SLOT_W'($urandom_range(1, 1024)));
    run_mix(100, 50, 60);

    settle();
    write_slot_count(SLOT_COUNT_RST);
    run_mix(20, 60, 30);

    settle();
    if (tracker.faults == 0 && tracker.due.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/edss_pkg.sv
rtl/edss_cell.sv
rtl/earliest_deadline_slot_scheduler.sv
sim/tb.sv
